>>> rtl/reliable_channel_sequencer_defines.svh
// Assertion macros shared by the reliable channel sequencer RTL.
`ifndef RELIABLE_CHANNEL_SEQUENCER_DEFINES_SVH
`define RELIABLE_CHANNEL_SEQUENCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcs: next-cycle check failed");

`endif

>>> rtl/rcs_pkg.sv
// Shared types, constants and serial-number helpers of the reliable channel sequencer.
`timescale 1ns / 1ps

package rcs_pkg;

    // Range table depth; must be a power of two so the index is a bit slice of the sequence.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SEQ_W       = 16;

    localparam logic [SEQ_W-1:0] SEQ_HALF        = 16'h7FFF;
    localparam logic [SEQ_W-1:0] PEND_MAX        = 16'hFFFF;
    localparam logic [SEQ_W-1:0] MAX_UNACKED_RST = 16'd64;

    typedef logic [SEQ_W-1:0] seq_t;

    typedef enum logic [1:0] {
        REQ_POST     = 2'd0,
        REQ_BUILD    = 2'd1,
        REQ_INCOMING = 2'd2,
        REQ_NONE     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        RX_OK        = 2'd0,
        RX_NO_ACK    = 2'd1,
        RX_TRUNCATED = 2'd2,
        RX_BAD       = 2'd3
    } rx_status_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic decide;
        logic sweep;
        logic load_out;
    } rcs_cmd_t;

    typedef struct packed {
        logic ack_found;
        logic sweep_done;
    } rcs_sts_t;

    // Per-item result fields settled in the decide step.
    typedef struct packed {
        logic accepted;
        logic tx_has_reliable;
        seq_t tx_sequence;
        seq_t tx_acked_seq;
        seq_t tx_first_message;
        seq_t tx_message_count;
        seq_t tx_ack;
        logic rx_received;
        seq_t skip_count;
    } rcs_res_t;

    function automatic logic newer_than(input seq_t a, input seq_t b);
        seq_t d;
        d = a - b;
        return ((d != '0) && (d <= SEQ_HALF)) || ((d == (SEQ_HALF + 16'd1)) && (a < b));
    endfunction

    function automatic seq_t wrap_distance(input seq_t a, input seq_t b);
        seq_t d;
        d = a - b;
        return (d <= SEQ_HALF) ? d : seq_t'(16'd0 - d);
    endfunction

endpackage

>>> rtl/reliable_channel_sequencer.sv
// Top level of the reliable channel sequencer: controller and datapath.
`timescale 1ns / 1ps

// Sequence and acknowledgement bookkeeping for one reliable channel with 16-bit
// wrapping serial numbers. Each input word (post, build or incoming) gives exactly one
// result word. Words are handled one at a time: for a post, a build, an incoming packet
// whose ack is not found, or an unknown request, the word passes the capture, lookup,
// decide and result steps, and the next word is taken only after the result is loaded
// into the output register. An incoming ack that is newer and found in the range table also
// sweeps the whole table through its single read port, one entry per cycle, with the
// compare trailing the read on the registered read data, before its result is loaded.
// A finished result waits in the output register while the next word is accepted; while
// that register still holds a stalled word, the next result waits in the result state
// until the register is free. The user must write the max_unacked register through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block itself does not enforce it.
module reliable_channel_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] ack_seq,
    input  logic        rx_has_header,
    input  logic [15:0] rx_sequence,
    input  logic [15:0] rx_first_message,
    input  logic [15:0] rx_message_count,
    input  logic [1:0]  rx_status,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        tx_has_reliable,
    output logic [15:0] tx_sequence,
    output logic [15:0] tx_acked_seq,
    output logic [15:0] tx_first_message,
    output logic [15:0] tx_message_count,
    output logic [15:0] tx_ack,
    output logic        rx_received,
    output logic [15:0] skip_count,
    output logic [15:0] unacked_sequences,
    output logic [15:0] pending_messages,
    output logic        ack_timeout
);
    import rcs_pkg::*;

    rcs_cmd_t cmd;
    rcs_sts_t sts;

    rcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rcs_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .req_type          (req_type),
        .ack_seq           (ack_seq),
        .rx_has_header     (rx_has_header),
        .rx_sequence       (rx_sequence),
        .rx_first_message  (rx_first_message),
        .rx_message_count  (rx_message_count),
        .rx_status         (rx_status),
        .accepted          (accepted),
        .tx_has_reliable   (tx_has_reliable),
        .tx_sequence       (tx_sequence),
        .tx_acked_seq      (tx_acked_seq),
        .tx_first_message  (tx_first_message),
        .tx_message_count  (tx_message_count),
        .tx_ack            (tx_ack),
        .rx_received       (rx_received),
        .skip_count        (skip_count),
        .unacked_sequences (unacked_sequences),
        .pending_messages  (pending_messages),
        .ack_timeout       (ack_timeout)
    );

endmodule

>>> rtl/rcs_datapath.sv
// Datapath: sequence state, range table memory with valid bits, sweep counter and result registers.
`timescale 1ns / 1ps

module rcs_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  rcs_pkg::rcs_cmd_t cmd,
    output rcs_pkg::rcs_sts_t sts,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic [1:0]        req_type,
    input  logic [15:0]       ack_seq,
    input  logic              rx_has_header,
    input  logic [15:0]       rx_sequence,
    input  logic [15:0]       rx_first_message,
    input  logic [15:0]       rx_message_count,
    input  logic [1:0]        rx_status,
    output logic              accepted,
    output logic              tx_has_reliable,
    output logic [15:0]       tx_sequence,
    output logic [15:0]       tx_acked_seq,
    output logic [15:0]       tx_first_message,
    output logic [15:0]       tx_message_count,
    output logic [15:0]       tx_ack,
    output logic              rx_received,
    output logic [15:0]       skip_count,
    output logic [15:0]       unacked_sequences,
    output logic [15:0]       pending_messages,
    output logic              ack_timeout
);
    import rcs_pkg::*;

    // Captured input word.
    req_type_t  cap_req_reg;
    seq_t       cap_ack_reg;
    logic       cap_has_rel_reg;
    seq_t       cap_rseq_reg;
    seq_t       cap_rfirst_reg;
    seq_t       cap_rcount_reg;
    rx_status_t cap_status_reg;

    // Channel state.
    seq_t tx_seq_reg, tx_seq_next;
    seq_t acked_seq_reg, acked_seq_next;
    seq_t first_pending_reg, first_pending_next;
    seq_t next_message_reg, next_message_next;
    seq_t rx_last_seq_reg, rx_last_seq_next;
    seq_t rx_next_message_reg, rx_next_message_next;
    seq_t max_unacked_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Range table: tag in the upper half, last message index in the lower half.
    logic [2*SEQ_W-1:0] mem [TABLE_DEPTH];
    logic [2*SEQ_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [2*SEQ_W-1:0] mem_wdata;

    rcs_res_t res_reg, res_next;

    // Output word.
    rcs_res_t out_res_reg;
    seq_t     out_unacked_reg;
    seq_t     out_pending_reg;
    logic     out_timeout_reg;

    seq_t     pend;
    seq_t     tx_seq_inc;
    seq_t     sweep_off;
    seq_t     sweep_span;
    seq_t     unacked_now;
    logic     status_ok;
    logic     found;

    assign pend        = next_message_reg - first_pending_reg;
    assign tx_seq_inc  = tx_seq_reg + 16'd1;
    assign status_ok   = (cap_status_reg == RX_OK) || (cap_status_reg == RX_TRUNCATED);
    assign found       = (cap_req_reg == REQ_INCOMING) && status_ok
                         && newer_than(cap_ack_reg, acked_seq_reg)
                         && valid_reg[cap_ack_reg[IDX_W-1:0]]
                         && (rd_data_reg[2*SEQ_W-1:SEQ_W] == cap_ack_reg);
    assign sweep_off   = rd_data_reg[2*SEQ_W-1:SEQ_W] - acked_seq_reg;
    assign sweep_span  = cap_ack_reg - acked_seq_reg;
    assign unacked_now = wrap_distance(tx_seq_reg, acked_seq_reg);

    assign sts.ack_found  = found;
    assign sts.sweep_done = (cnt_reg == CNT_W'(TABLE_DEPTH));

    assign rd_addr = cmd.lookup ? cap_ack_reg[IDX_W-1:0] : cnt_reg[IDX_W-1:0];

    always_comb
    begin
        seq_t off;
        tx_seq_next          = tx_seq_reg;
        acked_seq_next       = acked_seq_reg;
        first_pending_next   = first_pending_reg;
        next_message_next    = next_message_reg;
        rx_last_seq_next     = rx_last_seq_reg;
        rx_next_message_next = rx_next_message_reg;
        valid_next           = valid_reg;
        cnt_next             = cnt_reg;
        res_next             = res_reg;
        mem_we               = 1'b0;
        mem_waddr            = tx_seq_inc[IDX_W-1:0];
        mem_wdata            = {tx_seq_inc, next_message_reg};
        off                  = rd_data_reg[SEQ_W-1:0] - first_pending_reg;

        if (cmd.decide)
        begin
            res_next = '0;
            cnt_next = '0;
            case (cap_req_reg)
                REQ_POST:
                begin
                    if (pend != PEND_MAX)
                    begin
                        next_message_next = next_message_reg + 16'd1;
                        res_next.accepted = 1'b1;
                    end
                end
                REQ_BUILD:
                begin
                    res_next.accepted = 1'b1;
                    res_next.tx_ack   = rx_last_seq_reg;
                    if (pend != '0)
                    begin
                        tx_seq_next                 = tx_seq_inc;
                        mem_we                      = 1'b1;
                        valid_next[mem_waddr]       = 1'b1;
                        res_next.tx_has_reliable    = 1'b1;
                        res_next.tx_sequence        = tx_seq_inc;
                        res_next.tx_acked_seq       = acked_seq_reg;
                        res_next.tx_first_message   = first_pending_reg;
                        res_next.tx_message_count   = pend;
                    end
                end
                REQ_INCOMING:
                begin
                    if (status_ok)
                    begin
                        res_next.accepted = 1'b1;
                        if (found)
                        begin
                            // A recorded end beyond the pending window releases everything.
                            if (off > pend)
                                first_pending_next = next_message_reg;
                            else
                                first_pending_next = rd_data_reg[SEQ_W-1:0];
                        end
                        if ((cap_status_reg == RX_OK) && cap_has_rel_reg
                            && newer_than(cap_rseq_reg, rx_last_seq_reg))
                        begin
                            rx_last_seq_next     = cap_rseq_reg;
                            res_next.rx_received = 1'b1;
                            res_next.skip_count  = rx_next_message_reg - cap_rfirst_reg;
                            rx_next_message_next = cap_rfirst_reg + cap_rcount_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.sweep)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            // The compare stage trails the read: it works on the registered read data and index.
            if ((cnt_reg != '0) && valid_reg[rd_idx_reg] && (sweep_off <= sweep_span))
                valid_next[rd_idx_reg] = 1'b0;
            if (sts.sweep_done)
                acked_seq_next = cap_ack_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_seq_reg          <= '0;
            acked_seq_reg       <= '0;
            first_pending_reg   <= '0;
            next_message_reg    <= '0;
            rx_last_seq_reg     <= '0;
            rx_next_message_reg <= '0;
            max_unacked_reg     <= MAX_UNACKED_RST;
            valid_reg           <= '0;
            cnt_reg             <= '0;
        end
        else
        begin
            tx_seq_reg          <= tx_seq_next;
            acked_seq_reg       <= acked_seq_next;
            first_pending_reg   <= first_pending_next;
            next_message_reg    <= next_message_next;
            rx_last_seq_reg     <= rx_last_seq_next;
            rx_next_message_reg <= rx_next_message_next;
            valid_reg           <= valid_next;
            cnt_reg             <= cnt_next;
            if (cfg_wr_en)
                max_unacked_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_req_reg     <= req_type_t'(req_type);
            cap_ack_reg     <= ack_seq;
            cap_has_rel_reg <= rx_has_header;
            cap_rseq_reg    <= rx_sequence;
            cap_rfirst_reg  <= rx_first_message;
            cap_rcount_reg  <= rx_message_count;
            cap_status_reg  <= rx_status_t'(rx_status);
        end
        res_reg <= res_next;
        if (cmd.load_out)
        begin
            out_res_reg     <= res_reg;
            out_unacked_reg <= unacked_now;
            out_pending_reg <= pend;
            out_timeout_reg <= (unacked_now > max_unacked_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
    end

    assign accepted          = out_res_reg.accepted;
    assign tx_has_reliable   = out_res_reg.tx_has_reliable;
    assign tx_sequence       = out_res_reg.tx_sequence;
    assign tx_acked_seq      = out_res_reg.tx_acked_seq;
    assign tx_first_message  = out_res_reg.tx_first_message;
    assign tx_message_count  = out_res_reg.tx_message_count;
    assign tx_ack            = out_res_reg.tx_ack;
    assign rx_received       = out_res_reg.rx_received;
    assign skip_count        = out_res_reg.skip_count;
    assign unacked_sequences = out_unacked_reg;
    assign pending_messages  = out_pending_reg;
    assign ack_timeout       = out_timeout_reg;

endmodule

>>> rtl/rcs_ctrl.sv
// Controller state machine: input and output handshakes and sequencing of the datapath.
`timescale 1ns / 1ps
`include "reliable_channel_sequencer_defines.svh"

module rcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output rcs_pkg::rcs_cmd_t cmd,
    input  rcs_pkg::rcs_sts_t sts
);
    import rcs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.ack_found ? ST_CLEAR : ST_RESULT;
            end
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `RCS_ASSERT_NEXT(a_accept_to_lookup, in_valid && !in_stall, state_reg == ST_LOOKUP)
    `RCS_ASSERT_NEXT(a_miss_to_result, state_reg == ST_DECIDE && !sts.ack_found, state_reg == ST_RESULT)
    `RCS_ASSERT_NEXT(a_sweep_to_result, state_reg == ST_CLEAR && sts.sweep_done, state_reg == ST_RESULT)
    `RCS_ASSERT_SAME(a_load_needs_room, cmd.load_out, !out_valid_reg || !out_stall)
    `RCS_ASSERT_NEXT(a_load_shows_word, cmd.load_out, out_valid_reg)

endmodule

>>> test/reliable_channel_sequencer_checker.sv
// Watches both channels of the reliable channel sequencer, predicts each result word and compares.
`timescale 1ns / 1ps

module reliable_channel_sequencer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] ack_seq,
    input  logic        rx_has_header,
    input  logic [15:0] rx_sequence,
    input  logic [15:0] rx_first_message,
    input  logic [15:0] rx_message_count,
    input  logic [1:0]  rx_status,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        accepted,
    input  logic        tx_has_reliable,
    input  logic [15:0] tx_sequence,
    input  logic [15:0] tx_acked_seq,
    input  logic [15:0] tx_first_message,
    input  logic [15:0] tx_message_count,
    input  logic [15:0] tx_ack,
    input  logic        rx_received,
    input  logic [15:0] skip_count,
    input  logic [15:0] unacked_sequences,
    input  logic [15:0] pending_messages,
    input  logic        ack_timeout,
    output int          errors,
    output int          outstanding,
    output logic [15:0] seq_sent,
    output logic [15:0] seq_acked,
    output logic [15:0] seq_heard
);
    import rcs_pkg::*;

    typedef struct {
        logic        accepted;
        logic        tx_has_reliable;
        logic [15:0] tx_sequence;
        logic [15:0] tx_acked_seq;
        logic [15:0] tx_first_message;
        logic [15:0] tx_message_count;
        logic [15:0] tx_ack;
        logic        rx_received;
        logic [15:0] skip_count;
        logic [15:0] unacked_sequences;
        logic [15:0] pending_messages;
        logic        ack_timeout;
    } chan_word_t;

    typedef struct {
        logic        valid;
        logic [15:0] tag;
        logic [15:0] last;
    } span_entry_t;

    span_entry_t span_table [TABLE_DEPTH];
    logic [15:0] limit_unacked;
    logic [15:0] send_seq;
    logic [15:0] ack_mark;
    logic [15:0] first_open;
    logic [15:0] next_post;
    logic [15:0] heard_seq;
    logic [15:0] heard_next;
    chan_word_t  expected_words [$];
    chan_word_t  fresh_word;
    int          words_seen;

    function automatic logic is_later(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return ((d != 16'h0000) && (d <= 16'h7FFF)) || ((d == 16'h8000) && (a < b));
    endfunction

    function automatic logic [15:0] seq_gap(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d <= 16'h7FFF) ? d : 16'h0000 - d;
    endfunction

    task report_mismatch(input string msg);
        if (errors < 100)
            $display("checker: word %0d: %s", words_seen, msg);
        errors++;
    endtask

    // A newer ack that hits a live entry releases messages and clears every entry from the
    // old ack mark up to it.
    task release_through(input logic [15:0] ack);
        int          slot;
        logic [15:0] off;
        logic [15:0] pend;
        logic [15:0] span;
        logic [15:0] tag_off;
        slot = int'(ack) % TABLE_DEPTH;
        if (!is_later(ack, ack_mark))
            return;
        if (!span_table[slot].valid || span_table[slot].tag != ack)
            return;
        off = span_table[slot].last - first_open;
        pend = next_post - first_open;
        first_open = (off > pend) ? next_post : span_table[slot].last;
        span = ack - ack_mark;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tag_off = span_table[i].tag - ack_mark;
            if (span_table[i].valid && tag_off <= span)
                span_table[i].valid = 1'b0;
        end
        ack_mark = ack;
    endtask

    task apply_request(output chan_word_t w);
        logic [15:0] pend;
        int          slot;
        w = '{default: '0};
        pend = next_post - first_open;
        case (req_type)
            REQ_POST:
            begin
                if (pend != PEND_MAX)
                begin
                    next_post = next_post + 16'd1;
                    w.accepted = 1'b1;
                end
            end
            REQ_BUILD:
            begin
                w.accepted = 1'b1;
                if (pend != 16'd0)
                begin
                    send_seq = send_seq + 16'd1;
                    slot = int'(send_seq) % TABLE_DEPTH;
                    span_table[slot] = '{1'b1, send_seq, next_post};
                    w.tx_has_reliable = 1'b1;
                    w.tx_sequence = send_seq;
                    w.tx_acked_seq = ack_mark;
                    w.tx_first_message = first_open;
                    w.tx_message_count = pend;
                end
                w.tx_ack = heard_seq;
            end
            REQ_INCOMING:
            begin
                if (rx_status == RX_OK || rx_status == RX_TRUNCATED)
                begin
                    w.accepted = 1'b1;
                    release_through(ack_seq);
                    if (rx_status == RX_OK && rx_has_header && is_later(rx_sequence, heard_seq))
                    begin
                        heard_seq = rx_sequence;
                        w.rx_received = 1'b1;
                        w.skip_count = heard_next - rx_first_message;
                        heard_next = rx_first_message + rx_message_count;
                    end
                end
            end
            default:
            begin
            end
        endcase
        w.unacked_sequences = seq_gap(send_seq, ack_mark);
        w.pending_messages = next_post - first_open;
        w.ack_timeout = w.unacked_sequences > limit_unacked;
    endtask

    task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task check_word();
        chan_word_t want;
        words_seen++;
        if (expected_words.size() == 0)
        begin
            report_mismatch("result word with no request waiting");
            return;
        end
        want = expected_words.pop_front();
        check_field("accepted", 16'(accepted), 16'(want.accepted));
        check_field("tx_has_reliable", 16'(tx_has_reliable), 16'(want.tx_has_reliable));
        check_field("tx_sequence", tx_sequence, want.tx_sequence);
        check_field("tx_acked_seq", tx_acked_seq, want.tx_acked_seq);
        check_field("tx_first_message", tx_first_message, want.tx_first_message);
        check_field("tx_message_count", tx_message_count, want.tx_message_count);
        check_field("tx_ack", tx_ack, want.tx_ack);
        check_field("rx_received", 16'(rx_received), 16'(want.rx_received));
        check_field("skip_count", skip_count, want.skip_count);
        check_field("unacked_sequences", unacked_sequences, want.unacked_sequences);
        check_field("pending_messages", pending_messages, want.pending_messages);
        check_field("ack_timeout", 16'(ack_timeout), 16'(want.ack_timeout));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_unacked = MAX_UNACKED_RST;
            send_seq = '0;
            ack_mark = '0;
            first_open = '0;
            next_post = '0;
            heard_seq = '0;
            heard_next = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                span_table[i] = '{1'b0, 16'h0000, 16'h0000};
            expected_words.delete();
            errors = 0;
            words_seen = 0;
            outstanding <= 0;
            seq_sent <= '0;
            seq_acked <= '0;
            seq_heard <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_unacked = cfg_wr_data;
            // The result leaving now always belongs to an older word, so compare first.
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
            begin
                apply_request(fresh_word);
                expected_words.insert(expected_words.size(), fresh_word);
            end
            outstanding <= expected_words.size();
            seq_sent <= send_seq;
            seq_acked <= ack_mark;
            seq_heard <= heard_seq;
        end
    end

endmodule

>>> test/reliable_channel_sequencer_test.sv
// Testbench top for the reliable channel sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module reliable_channel_sequencer_test;
    import rcs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [15:0] ack_seq = '0;
    logic        rx_has_header = 1'b0;
    logic [15:0] rx_sequence = '0;
    logic [15:0] rx_first_message = '0;
    logic [15:0] rx_message_count = '0;
    logic [1:0]  rx_status = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        accepted;
    logic        tx_has_reliable;
    logic [15:0] tx_sequence;
    logic [15:0] tx_acked_seq;
    logic [15:0] tx_first_message;
    logic [15:0] tx_message_count;
    logic [15:0] tx_ack;
    logic        rx_received;
    logic [15:0] skip_count;
    logic [15:0] unacked_sequences;
    logic [15:0] pending_messages;
    logic        ack_timeout;

    int          errors;
    int          outstanding;
    logic [15:0] seq_sent;
    logic [15:0] seq_acked;
    logic [15:0] seq_heard;

    int          gap_pct = 0;
    int          stall_pct = 0;

    reliable_channel_sequencer dut (.*);

    reliable_channel_sequencer_checker watch (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver stalls come in bursts whose frequency follows stall_pct.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic send_word(input logic [1:0] req, input logic [15:0] ack, input logic rel,
                             input logic [15:0] rseq, input logic [15:0] rfirst,
                             input logic [15:0] rcount, input logic [1:0] status);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        ack_seq <= ack;
        rx_has_header <= rel;
        rx_sequence <= rseq;
        rx_first_message <= rfirst;
        rx_message_count <= rcount;
        rx_status <= status;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_plain(input logic [1:0] req);
        send_word(req, rnd16(), 1'($urandom_range(0, 1)), rnd16(), rnd16(), rnd16(),
                  2'($urandom_range(0, 3)));
    endtask

    // Mostly acks that land between the last ack and the newest sequence sent.
    function automatic logic [15:0] pick_ack();
        logic [15:0] span_len;
        int          roll;
        span_len = seq_sent - seq_acked;
        roll = $urandom_range(0, 9);
        if (roll < 7 && span_len != 16'd0 && span_len <= 16'h7FFF)
            return seq_acked + 16'($urandom_range(1, (span_len > 16'd70) ? 70 : int'(span_len)));
        if (roll == 7)
            return seq_acked + 16'h8000;
        if (roll == 8)
            return seq_acked;
        return rnd16();
    endfunction

    task automatic send_incoming(input logic [1:0] status);
        logic [15:0] rseq;
        logic [15:0] rcount;
        rseq = ($urandom_range(0, 9) < 8) ? seq_heard + 16'($urandom_range(1, 8)) : rnd16();
        rcount = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : rnd16();
        send_word(REQ_INCOMING, pick_ack(), 1'($urandom_range(0, 9) != 0), rseq, rnd16(),
                  rcount, status);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [15:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_run(input int count);
        int n;
        int pick;
        int posts;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                posts = $urandom_range(1, 4);
                repeat (posts) send_plain(REQ_POST);
                send_plain(REQ_BUILD);
                n += posts + 1;
            end
            else if (pick < 70)
            begin
                send_incoming(($urandom_range(0, 9) != 0) ? RX_OK : RX_TRUNCATED);
                n++;
            end
            else if (pick < 80)
            begin
                send_plain(REQ_BUILD);
                n++;
            end
            else if (pick < 85)
            begin
                send_plain(REQ_POST);
                n++;
            end
            else if (pick < 95)
            begin
                send_plain(2'($urandom_range(0, 3)));
                n++;
            end
            else
            begin
                send_incoming(($urandom_range(0, 1) != 0) ? RX_NO_ACK : RX_BAD);
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: any unacked sequence counts as timed out here.
        set_limit(16'h0000);
        send_word(REQ_NONE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, RX_BAD);
        send_word(REQ_BUILD, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_INCOMING, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_POST, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_POST, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_BUILD, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_POST, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_BUILD, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_BUILD, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        // Ack of sequence 2 is found; the header at half-range distance is not newer.
        send_word(REQ_INCOMING, 16'h0002, 1'b1, 16'h8000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_INCOMING, 16'h0002, 1'b1, 16'h7FFF, 16'hFFFF, 16'hFFFF, RX_OK);
        send_word(REQ_INCOMING, 16'h0003, 1'b1, 16'h8000, 16'h0000, 16'h0000, RX_TRUNCATED);
        send_word(REQ_INCOMING, 16'hFFFF, 1'b1, 16'h8000, 16'h0000, 16'h0000, RX_NO_ACK);
        send_word(REQ_INCOMING, 16'hFFFF, 1'b1, 16'h8000, 16'h0000, 16'h0000, RX_BAD);
        send_word(REQ_INCOMING, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_INCOMING, 16'h8003, 1'b1, 16'hC000, 16'h1234, 16'h0000, RX_OK);
        // Half-range distance with the new sequence below the old one counts as newer.
        send_word(REQ_INCOMING, 16'h0000, 1'b1, 16'h4000, 16'h0000, 16'h0005, RX_OK);
        send_word(REQ_INCOMING, 16'h0000, 1'b0, 16'h4001, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_POST, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_BUILD, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, RX_OK);
        send_word(REQ_POST, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, RX_BAD);

        set_limit(16'hFFFF);
        gap_pct = 25;
        stall_pct = 25;
        random_run(450);

        set_limit(16'h0001);
        gap_pct = 50;
        stall_pct = 10;
        random_run(450);

        set_limit(16'($urandom_range(2, 100)));
        gap_pct = 10;
        stall_pct = 50;
        random_run(450);

        set_limit(MAX_UNACKED_RST);
        gap_pct = 30;
        stall_pct = 30;
        random_run(400);

        gap_pct = 0;
        stall_pct = 0;
        random_run(120);
        settle();
        repeat (80) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
